>>> src/hlcf_pkg.sv
// Shared types and constants for the header/length/checksum framer.
package hlcf_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int CNT_W = 3;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam logic REG_HEADER = 1'b0;
  localparam logic [7:0] HEADER_RESET = 8'h55;

  typedef struct packed {
    logic       frame_open;
    logic [7:0] bytes_remaining;
    logic [7:0] running_sum;
  } frame_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       error;
  } result_t;

  typedef result_t [MAX_RESULTS-1:0] result_set_t;

endpackage

>>> src/hlcf_step.sv
// Per-word frame step: result words and next frame state for one input word.
module hlcf_step (
  input  hlcf_pkg::frame_state_t     state,
  input  logic                       kind,
  input  logic [7:0]                 frame_type,
  input  logic [7:0]                 payload_length,
  input  logic [7:0]                 data_byte,
  input  logic [7:0]                 header_byte,
  output hlcf_pkg::frame_state_t     state_next,
  output hlcf_pkg::result_set_t      results,
  output logic [hlcf_pkg::CNT_W-1:0] result_count
);

  logic [7:0] start_sum;
  logic [7:0] payload_sum;
  logic [7:0] remaining_dec;
  hlcf_pkg::result_t err_word;

  assign start_sum = frame_type + payload_length;
  assign payload_sum = state.running_sum + data_byte;
  assign remaining_dec = state.bytes_remaining - 8'd1;

  always_comb begin
    err_word = '{out_byte: 8'h00, run_last: 1'b1, frame_end: 1'b0, error: 1'b1};
    state_next = state;
    results = '0;
    result_count = hlcf_pkg::CNT_W'(1);
    if (kind == hlcf_pkg::KIND_START) begin
      if (state.frame_open) begin
        results[0] = err_word;
      end else begin
        results[0] = '{out_byte: header_byte, run_last: 1'b0, frame_end: 1'b0, error: 1'b0};
        results[1] = '{out_byte: header_byte, run_last: 1'b0, frame_end: 1'b0, error: 1'b0};
        results[2] = '{out_byte: frame_type, run_last: 1'b0, frame_end: 1'b0, error: 1'b0};
        state_next.running_sum = start_sum;
        state_next.bytes_remaining = payload_length;
        if (payload_length == 8'd0) begin
          results[3] = '{out_byte: payload_length, run_last: 1'b0, frame_end: 1'b0,
                         error: 1'b0};
          results[4] = '{out_byte: ~start_sum, run_last: 1'b1, frame_end: 1'b1,
                         error: 1'b0};
          state_next.frame_open = 1'b0;
          result_count = hlcf_pkg::CNT_W'(5);
        end else begin
          results[3] = '{out_byte: payload_length, run_last: 1'b1, frame_end: 1'b0,
                         error: 1'b0};
          state_next.frame_open = 1'b1;
          result_count = hlcf_pkg::CNT_W'(4);
        end
      end
    end else begin
      if (!state.frame_open) begin
        results[0] = err_word;
      end else begin
        state_next.running_sum = payload_sum;
        state_next.bytes_remaining = remaining_dec;
        if (remaining_dec == 8'd0) begin
          results[0] = '{out_byte: data_byte, run_last: 1'b0, frame_end: 1'b0, error: 1'b0};
          results[1] = '{out_byte: ~payload_sum, run_last: 1'b1, frame_end: 1'b1,
                         error: 1'b0};
          state_next.frame_open = 1'b0;
          result_count = hlcf_pkg::CNT_W'(2);
        end else begin
          results[0] = '{out_byte: data_byte, run_last: 1'b1, frame_end: 1'b0, error: 1'b0};
        end
      end
    end
  end

endmodule

>>> src/header_length_checksum_framer_core.sv
// Header/length/checksum framer core: top level.
// The first result word is presented in the cycle after the input word is accepted.
// One output word per cycle while m_tready is high; the next input word is taken once the
// queue empties or its last word pops (1 or 2 words per payload word, 1, 4 or 5 per start).
// Reset: synchronous; clears frame state and the output queue, header byte to 0x55.
module header_length_checksum_framer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // frame_type[7:0], payload_length[15:8], data_byte[23:16]
  input  logic        s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // frame_end[0], error[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] header_byte;
  hlcf_pkg::frame_state_t state;
  hlcf_pkg::frame_state_t state_next;
  hlcf_pkg::result_set_t step_results;
  hlcf_pkg::result_set_t queue;
  logic [hlcf_pkg::CNT_W-1:0] step_count;
  logic [hlcf_pkg::CNT_W-1:0] count;
  logic in_accept;
  logic out_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == hlcf_pkg::REG_HEADER) ? {24'h0, header_byte} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= hlcf_pkg::HEADER_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == hlcf_pkg::REG_HEADER) begin
      header_byte <= pwdata[7:0];
    end
  end

  hlcf_step u_step (
    .state          (state),
    .kind           (s_tuser),
    .frame_type     (s_tdata[7:0]),
    .payload_length (s_tdata[15:8]),
    .data_byte      (s_tdata[23:16]),
    .header_byte    (header_byte),
    .state_next     (state_next),
    .results        (step_results),
    .result_count   (step_count)
  );

  assign m_tvalid = (count != '0);
  assign out_pop = m_tvalid && m_tready;
  assign s_tready = (count == '0) || (count == hlcf_pkg::CNT_W'(1) && m_tready);
  assign in_accept = s_tvalid && s_tready;

  assign m_tdata = queue[0].out_byte;
  assign m_tlast = queue[0].run_last;
  assign m_tuser = {queue[0].error, queue[0].frame_end};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      count <= '0;
    end else if (in_accept) begin
      state <= state_next;
      count <= step_count;
    end else if (out_pop) begin
      count <= count - hlcf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      queue <= step_results;
    end else if (out_pop) begin
      for (int i = 0; i < hlcf_pkg::MAX_RESULTS - 1; i++) begin
        queue[i] <= queue[i+1];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state.frame_open == (state.bytes_remaining != 8'd0))
    else $error("frame open flag disagrees with remaining byte count");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> count == hlcf_pkg::CNT_W'(1))
    else $error("last word of a run is not the last queued word");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && !m_tuser[1])
    else $error("checksum word not closing its run");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == 8'h00 && m_tlast && count == hlcf_pkg::CNT_W'(1))
    else $error("malformed error word");

endmodule

>>> test/tb.sv
// Self-checking testbench for the header/length/checksum framer core.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [2:0] HEADER_ADDR = {hlcf_pkg::REG_HEADER, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // frame_type[7:0], payload_length[15:8], data_byte[23:16]
  logic        s_tuser = 1'b0; // kind[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // out_byte[7:0]
  logic        m_tlast;
  logic [1:0]  m_tuser;        // frame_end[0], error[1]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  header_length_checksum_framer_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // framer state as predicted
  logic [7:0]        sync_byte = hlcf_pkg::HEADER_RESET;
  logic              in_frame = 1'b0;
  logic [7:0]        left_in_frame = '0;
  logic [7:0]        sum_so_far = '0;
  hlcf_pkg::result_t pending_bytes[$];

  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int frames_opened = 0;
  int words_refused = 0;
  int bytes_checked = 0;
  hlcf_pkg::result_t want;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatches++;
    $display("ERROR at cycle %0d: %s got %0h want %0h", cycles, what, got, exp_val);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last, input logic fend,
                           input logic err);
    hlcf_pkg::result_t r;
    r.out_byte = b;
    r.run_last = last;
    r.frame_end = fend;
    r.error = err;
    pending_bytes.push_back(r);
  endtask

  task automatic frame_bytes_for(input logic kind, input logic [7:0] ftype,
                                 input logic [7:0] len, input logic [7:0] dbyte);
    if (kind == hlcf_pkg::KIND_START) begin
      if (in_frame) begin
        words_refused++;
        push_byte(8'h00, 1'b1, 1'b0, 1'b1);
      end else begin
        frames_opened++;
        sum_so_far = ftype + len;
        push_byte(sync_byte, 1'b0, 1'b0, 1'b0);
        push_byte(sync_byte, 1'b0, 1'b0, 1'b0);
        push_byte(ftype, 1'b0, 1'b0, 1'b0);
        if (len == 8'h00) begin
          push_byte(len, 1'b0, 1'b0, 1'b0);
          push_byte(~sum_so_far, 1'b1, 1'b1, 1'b0);
          left_in_frame = 8'h00;
        end else begin
          push_byte(len, 1'b1, 1'b0, 1'b0);
          in_frame = 1'b1;
          left_in_frame = len;
        end
      end
    end else if (!in_frame) begin
      words_refused++;
      push_byte(8'h00, 1'b1, 1'b0, 1'b1);
    end else begin
      sum_so_far = sum_so_far + dbyte;
      left_in_frame = left_in_frame - 8'd1;
      if (left_in_frame == 8'h00) begin
        push_byte(dbyte, 1'b0, 1'b0, 1'b0);
        push_byte(~sum_so_far, 1'b1, 1'b1, 1'b0);
        in_frame = 1'b0;
      end else begin
        push_byte(dbyte, 1'b1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic send_word(input logic kind, input logic [7:0] ftype,
                           input logic [7:0] len, input logic [7:0] dbyte);
    while (src_gaps && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {dbyte, len, ftype};
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    frame_bytes_for(kind, ftype, len, dbyte);
  endtask

  task automatic send_random_payload();
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == HEADER_ADDR) sync_byte = data[7:0];
  endtask

  task automatic check_header_reg();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= HEADER_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'h0, sync_byte})
      report_mismatch("header register", int'(prdata), int'(sync_byte));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_header();
    check_header_reg();
    send_word(hlcf_pkg::KIND_START, 8'h00, 8'h00, 8'hFF);
    wait_drained();
  endtask

  task automatic test_directed_frames();
    send_word(hlcf_pkg::KIND_START, 8'hFF, 8'h01, 8'h00);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'h00, 8'hFF, 8'hFF);
    send_word(hlcf_pkg::KIND_START, 8'h80, 8'h02, 8'h5A);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'hFF, 8'h00, 8'h00);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h7F);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'hA5, 8'h3C, 8'hAA);
    send_word(hlcf_pkg::KIND_START, 8'h12, 8'h03, 8'h00);
    send_word(hlcf_pkg::KIND_START, 8'h34, 8'h00, 8'hFF);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h01);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h02);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h03);
    send_word(hlcf_pkg::KIND_START, 8'hFF, 8'h02, 8'h00);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'hFF);
    send_word(hlcf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'hFF);
    send_word(hlcf_pkg::KIND_START, 8'h01, 8'hFF, 8'h00);
    send_word(hlcf_pkg::KIND_START, 8'h00, 8'h00, 8'h00);
    wait_drained();
  endtask

  task automatic test_header_values();
    logic [31:0] values[4];
    values = '{32'hFF, 32'h00, 32'($urandom_range(255)), 32'(hlcf_pkg::HEADER_RESET)};
    foreach (values[i]) begin
      reg_write(HEADER_ADDR, values[i]);
      check_header_reg();
      send_word(hlcf_pkg::KIND_START, 8'($urandom_range(255)), 8'h00,
                8'($urandom_range(255)));
      send_word(hlcf_pkg::KIND_START, 8'($urandom_range(255)), 8'h01,
                8'($urandom_range(255)));
      send_random_payload();
      wait_drained();
    end
    // writes beyond the header register leave it untouched
    reg_write(SPARE_ADDR, 32'hA3);
    check_header_reg();
    send_word(hlcf_pkg::KIND_START, 8'h3C, 8'h00, 8'hC3);
    wait_drained();
  endtask

  task automatic test_random_frames(input int count);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_random_payload();
        sent++;
      end else begin
        len = (pick < 80) ? $urandom_range(6) : $urandom_range(24, 7);
        send_word(hlcf_pkg::KIND_START, 8'($urandom_range(255)), 8'(len),
                  8'($urandom_range(255)));
        sent++;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 3) begin
            send_word(hlcf_pkg::KIND_START, 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
            sent++;
          end
          if ($urandom_range(199) == 0) break;
          send_random_payload();
          sent++;
        end
      end
    end
  endtask

  task automatic test_longest_frame();
    send_word(hlcf_pkg::KIND_START, 8'($urandom_range(255)), 8'hFF,
              8'($urandom_range(255)));
    repeat (255) send_random_payload();
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !sink_gaps || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected result byte", int'(m_tdata), 0);
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (m_tdata !== want.out_byte)
          report_mismatch("out_byte", int'(m_tdata), int'(want.out_byte));
        if (m_tlast !== want.run_last)
          report_mismatch("run_last", int'(m_tlast), int'(want.run_last));
        if (m_tuser[0] !== want.frame_end)
          report_mismatch("frame_end", int'(m_tuser[0]), int'(want.frame_end));
        if (m_tuser[1] !== want.error)
          report_mismatch("error", int'(m_tuser[1]), int'(want.error));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d result bytes outstanding", pending_bytes.size());
      $display("header_length_checksum_framer_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_header();
    test_directed_frames();
    test_header_values();
    test_random_frames(40);
    wait_drained();
    reg_write(HEADER_ADDR, 32'($urandom_range(255)));
    test_longest_frame();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    test_random_frames(25);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    test_random_frames(25);
    wait_drained();
    $display("ran %0d input words: %0d frames opened, %0d out-of-sequence words refused",
             words_sent, frames_opened, words_refused);
    $display("checked %0d result bytes over several sync byte settings", bytes_checked);
    if (mismatches == 0) begin
      $display("header_length_checksum_framer_core: match");
    end else begin
      $display("header_length_checksum_framer_core: mismatch");
    end
    $finish;
  end

endmodule

>>> header_length_checksum_framer_core.f
src/hlcf_pkg.sv
src/hlcf_step.sv
src/header_length_checksum_framer_core.sv
test/tb.sv
